/* design/nlms_pkg.sv */
// package for the nlms adaptive fir core: types, register indexes, q15 helpers
// no dependencies
`timescale 1ns / 1ps
package nlms_pkg;

    localparam int MAX_TAPS_DEF = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_COUNT   = 3'd0,
        REG_STEP_ALPHA  = 3'd1,
        REG_REG_OFFSET  = 3'd2,
        REG_POWER_DECAY = 3'd3,
        REG_POWER_GAIN  = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PWR1,
        S_PWR2,
        S_DIV0,
        S_RUN,
        S_ERR,
        S_UE,
        S_UPD,
        S_OUT
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic               shift;
        logic               update;
        logic signed [15:0] ue;
    } cell_ctl_t;

    function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
        logic signed [15:0] r;
        if (v > 33'sd32767)
            r = 16'sh7fff;
        else if (v < -33'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] mul_r(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        logic signed [32:0] p;
        p = 33'(a * b) + 33'sh4000;
        return sat16(p >>> 15);
    endfunction

    function automatic logic signed [15:0] add16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        return sat16(33'(a) + 33'(b));
    endfunction

    function automatic logic signed [31:0] lmul(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        logic signed [32:0] p;
        p = 33'(a * b) <<< 1;
        return sat32(p);
    endfunction

endpackage

/* design/nlms_in_if.sv */
// input channel: sample and desired value with valid/ready
// no dependencies
`timescale 1ns / 1ps
interface nlms_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;
    logic signed [15:0] desired;

    modport source (output valid, output sample_in, output desired, input ready);
    modport sink (input valid, input sample_in, input desired, output ready);
endinterface

/* design/nlms_out_if.sv */
// output channel: filter output and error with valid/ready
// no dependencies
`timescale 1ns / 1ps
interface nlms_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filter_out;
    logic signed [15:0] error_out;

    modport source (output valid, output filter_out, output error_out, input ready);
    modport sink (input valid, input filter_out, input error_out, output ready);
endinterface

/* design/nlms_cell.sv */
// one tap cell: delay-line sample, weight, and a stage of the systolic mac chain
// depends on nlms_pkg
`timescale 1ns / 1ps
module nlms_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      active,
    input  nlms_pkg::cell_ctl_t       ctl,
    input  logic signed [15:0]        x_prev,
    input  logic signed [31:0]        acc_prev,
    output logic signed [15:0]        x,
    output logic signed [31:0]        acc
);
    import nlms_pkg::*;

    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] w_reg, w_next;
    logic signed [31:0] acc_reg, acc_next;

    always_comb
    begin
        x_next   = x_reg;
        w_next   = w_reg;
        acc_next = acc_prev;
        if (active)
        begin
            acc_next = sat32(33'(acc_prev) + 33'(lmul(w_reg, x_reg)));
            if (ctl.shift)
                x_next = x_prev;
            if (ctl.update)
                w_next = add16(w_reg, mul_r(ctl.ue, x_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            w_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            x_reg   <= x_next;
            w_reg   <= w_next;
            acc_reg <= acc_next;
        end
    end

    assign x   = x_reg;
    assign acc = acc_reg;
endmodule

/* design/nlms_div.sv */
// restoring divider for the step size, one quotient bit per cycle
// depends on nlms_pkg
`timescale 1ns / 1ps
module nlms_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [14:0]        num,
    input  logic [14:0]        den,
    output logic               busy,
    output logic signed [15:0] mu
);
    import nlms_pkg::*;

    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [14:0] rem_reg, rem_next;
    logic [14:0] quo_reg, quo_next;
    logic [14:0] den_reg, den_next;
    logic [15:0] trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[14]};
        if (start)
        begin
            cnt_next  = 4'd15;
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 15'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[13:0], 1'b1};
            end
            else
            begin
                rem_next = trial[14:0];
                quo_next = {quo_reg[13:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // zero divisor saturates the step size
    assign mu   = (den_reg == '0) ? 16'sh7fff : signed'({1'b0, quo_reg});
    assign busy = busy_reg;
endmodule

/* design/nlms_adaptive_fir_q15_core.sv */
// top level of the q15 normalized lms adaptive fir filter
// depends on nlms_pkg, nlms_in_if, nlms_out_if, nlms_cell, nlms_div
`timescale 1ns / 1ps
// One sample is handled at a time; the time from input transfer to the earliest
// result transfer is set by the systolic sum that runs through the row of
// MAX_TAPS tap cells, and the step-size divider runs alongside it and is hidden
// for MAX_TAPS of 18 or more. The next sample can be taken in the cycle the
// result is first offered, but not before the last sample is through. Each cell
// holds one delay-line sample and one weight; all active cells adapt their
// weight in the same cycle. A finished result waits in the output register while
// the next sample is taken. tap_count of zero acts as one tap, counts above
// MAX_TAPS act as MAX_TAPS. No clearing pass after reset.
module nlms_adaptive_fir_q15_core #(
    parameter int MAX_TAPS = nlms_pkg::MAX_TAPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nlms_in_if.sink                         in_ch,
    nlms_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [nlms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nlms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nlms_pkg::*;

    localparam int CW = $clog2(MAX_TAPS + 1);

    state_t state_reg, state_next;

    logic [5:0]  tap_count_reg;
    logic [14:0] step_alpha_reg, reg_offset_reg, power_decay_reg, power_gain_reg;

    logic signed [15:0] x0_reg, des_reg, p_reg, d_reg, power_reg, fout_reg, err_reg;
    logic signed [15:0] ue_reg;
    logic signed [15:0] out_f_reg, out_e_reg;
    logic               out_valid_reg;
    logic [CW-1:0]      cnt_reg;

    logic signed [15:0] xs   [MAX_TAPS];
    logic signed [31:0] accs [MAX_TAPS];
    cell_ctl_t          ctl;

    logic               in_xfer, out_load, div_start, div_busy;
    logic signed [15:0] mu, t_sum;
    logic signed [31:0] acc_rnd;
    logic signed [15:0] fout_c;

    assign in_xfer = in_ch.valid && in_ch.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg   <= 6'd16;
            step_alpha_reg  <= 15'd16384;
            reg_offset_reg  <= 15'd1;
            power_decay_reg <= 15'd32440;
            power_gain_reg  <= 15'd328;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAP_COUNT:   tap_count_reg   <= cfg_data[5:0];
                REG_STEP_ALPHA:  step_alpha_reg  <= cfg_data;
                REG_REG_OFFSET:  reg_offset_reg  <= cfg_data;
                REG_POWER_DECAY: power_decay_reg <= cfg_data;
                REG_POWER_GAIN:  power_gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_PWR1;
            S_PWR1: state_next = S_PWR2;
            S_PWR2: state_next = S_DIV0;
            S_DIV0: state_next = S_RUN;
            S_RUN:
                if (!div_busy && cnt_reg >= CW'(MAX_TAPS))
                    state_next = S_ERR;
            S_ERR:  state_next = S_UE;
            S_UE:   state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctl.shift   = (state_reg == S_IDLE) && in_xfer;
        ctl.update  = (state_reg == S_UPD);
        ctl.ue      = ue_reg;
        div_start   = (state_reg == S_DIV0);
        out_load    = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);
        in_ch.ready = (state_reg == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (in_xfer)
                cnt_reg <= '0;
            else if (cnt_reg < CW'(MAX_TAPS))
                cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign t_sum   = add16(signed'({1'b0, reg_offset_reg}), power_reg);
    assign acc_rnd = sat32(33'(accs[MAX_TAPS-1]) + 33'sh8000);
    assign fout_c  = acc_rnd[31:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            power_reg <= '0;
        else if (state_reg == S_PWR2)
            power_reg <= add16(d_reg, mul_r(p_reg, signed'({1'b0, power_gain_reg})));
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x0_reg  <= in_ch.sample_in;
            des_reg <= in_ch.desired;
        end
        if (state_reg == S_PWR1)
        begin
            p_reg <= mul_r(x0_reg, x0_reg);
            d_reg <= mul_r(power_reg, signed'({1'b0, power_decay_reg}));
        end
        if (state_reg == S_ERR)
        begin
            fout_reg <= fout_c;
            err_reg  <= sat16(33'(des_reg) - 33'(fout_c));
        end
        if (out_load)
        begin
            out_f_reg <= fout_reg;
            out_e_reg <= err_reg;
        end
    end

    // error times step size, registered in the cycle after the error
    always_ff @(posedge clk)
    begin
        ue_reg <= mul_r(err_reg, mu);
    end

    nlms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (step_alpha_reg),
        .den   (t_sum[15:1]),
        .busy  (div_busy),
        .mu    (mu)
    );

    genvar j;
    generate
        for (j = 0; j < MAX_TAPS; j++)
        begin : g_cell
            logic               act;
            logic signed [15:0] xp;
            logic signed [31:0] ap;
            if (j == 0)
            begin : g_first
                assign act = 1'b1;
                assign xp  = in_ch.sample_in;
                assign ap  = '0;
            end
            else
            begin : g_rest
                assign act = ({26'b0, tap_count_reg} > 32'(j));
                assign xp  = xs[j-1];
                assign ap  = accs[j-1];
            end
            nlms_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (act),
                .ctl      (ctl),
                .x_prev   (xp),
                .acc_prev (ap),
                .x        (xs[j]),
                .acc      (accs[j])
            );
        end
    endgenerate

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.filter_out = out_f_reg;
    assign out_ch.error_out  = out_e_reg;
endmodule

/* design/nlms_chk.sv */
// port-level checker for the nlms core, attached by bind
// depends on the top level port list only
`timescale 1ns / 1ps
module nlms_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] filter_out,
    input logic [15:0] error_out
);
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a sample is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared right after input transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(filter_out) && $stable(error_out)))
        else $error("result changed while stalled");
endmodule

bind nlms_adaptive_fir_q15_core nlms_chk u_nlms_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .filter_out (out_ch.filter_out),
    .error_out  (out_ch.error_out)
);
